// ===== src/flsc_pkg.sv =====
// Package for the frame slot LRU cache: sizes, codes, item and token types.
// Used by flsc_cell and frame_slot_lru_cache; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package flsc_pkg;

	localparam int SLOTS  = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [31:0] TAG_RESET     = 32'h0fff_ffff;
	localparam logic [31:0] STAMP_RESET   = 32'h00ff_ffff;
	localparam logic [31:0] RESERVED_TAG  = 32'hffff_ffff;
	localparam logic [31:0] RESERVE_AHEAD = 32'd1000;

	localparam logic [1:0] OP_LOOKUP   = 2'd0;
	localparam logic [1:0] OP_ALLOCATE = 2'd1;
	localparam logic [1:0] OP_FILL     = 2'd2;

	localparam logic [1:0] ST_DONE         = 2'd0;
	localparam logic [1:0] ST_MISS         = 2'd1;
	localparam logic [1:0] ST_NOT_RESERVED = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] frame_number;
		logic [2:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
	} out_item_t;

	// Running scan result that walks down the row of cells.
	typedef struct packed {
		logic              vld;
		logic [1:0]        op;
		logic [31:0]       frame;
		logic [2:0]        idx;
		logic [SLOT_W-1:0] pos;
		logic              found;
		logic [31:0]       best;
		logic [SLOT_W-1:0] pick;
	} token_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] stamp;
	} wr_data_t;

endpackage

`default_nettype wire

// ===== src/flsc_cell.sv =====
// One slot of the frame slot LRU cache: tag, stamp and one scan stage.
// Depends on flsc_pkg for the token and write types.
`timescale 1ns / 1ps
`default_nettype none

module flsc_cell import flsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] counter,
	input  wire token_t      tok_in,
	output token_t           tok_out,
	input  wire logic        wr_en,
	input  wire wr_data_t    wr
);

	logic [31:0] tag_q;
	logic [31:0] stamp_q;
	logic [31:0] mag_q;
	logic [31:0] diff;
	logic [31:0] mag;
	token_t      tok_next;
	token_t      tok_q;

	assign diff = counter - stamp_q;
	assign mag  = diff[31] ? (32'd0 - diff) : diff;

	always_comb begin
		tok_next     = tok_in;
		tok_next.pos = SLOT_W'(tok_in.pos + 1'b1);
		case (tok_in.op)
			OP_LOOKUP: begin
				if (!tok_in.found && tag_q == tok_in.frame && tok_in.frame != RESERVED_TAG) begin
					tok_next.found = 1'b1;
					tok_next.pick  = tok_in.pos;
				end
			end
			OP_ALLOCATE: begin
				if (mag_q > tok_in.best) begin
					tok_next.best = mag_q;
					tok_next.pick = tok_in.pos;
				end
			end
			OP_FILL: begin
				if (32'(tok_in.pos) == 32'(tok_in.idx) && tag_q == RESERVED_TAG) begin
					tok_next.found = 1'b1;
					tok_next.pick  = tok_in.pos;
				end
			end
			default: begin
				tok_next.found = tok_in.found;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= TAG_RESET;
			stamp_q <= STAMP_RESET;
		end else if (wr_en) begin
			tag_q   <= wr.tag;
			stamp_q <= wr.stamp;
		end
	end

	// The distance is taken once per item, while the counter is steady.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.vld) begin
			tok_q <= tok_next;
		end else begin
			tok_q.vld <= 1'b0;
		end
	end

	assign tok_out = tok_q;

	a_tok_moves: assert property (@(posedge clk) disable iff (!arst_n)
		tok_in.vld |=> tok_out.vld)
		else $error("scan token did not advance through cell");

	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (tag_q == $past(wr.tag) && stamp_q == $past(wr.stamp)))
		else $error("slot write did not land");

	a_start_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && tok_in.vld))
		else $error("distance latch overlaps a scan token");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && tok_in.vld))
		else $error("slot written while its scan stage is active");

endmodule

`default_nettype wire

// ===== src/frame_slot_lru_cache.sv =====
// Top level of the frame slot LRU cache: row of slot cells and scan control.
// Depends on flsc_pkg and flsc_cell.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps SLOTS frame numbers in a row of cells, one slot per cell,
// and serves three operations: lookup, allocate and fill. Every operation
// runs as a scan token that walks down the row one cell per clock; each cell
// folds its own tag match or LRU distance into the token, so the lowest
// matching slot wins a lookup and the first slot with the largest distance
// between use counter and stamp wins an allocate (slot 0 when all are zero).
// When the token leaves the last cell the chosen slot is written (except on
// a lookup miss), the use counter is advanced for a lookup hit or a
// successful fill, and the result is registered for the output channel.
// Only one item is in work at a time, and item_stall stays high until its
// result sits in the output register, which can wait on result_stall
// without holding up the next input transfer. A lookup of all ones always
// misses, since that tag marks a reserved slot. A fill of a slot that is
// not reserved returns status 2 and leaves the state untouched.
module frame_slot_lru_cache import flsc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item,
	input  wire logic     item_valid,
	output logic          item_stall,
	output out_item_t     result,
	output logic          result_valid,
	input  wire logic     result_stall
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t      state_q;
	logic        accept;
	logic        out_free;
	logic        res_load;
	logic [31:0] counter_q;
	token_t      head_q;
	token_t      tok [SLOTS+1];
	token_t      last;
	out_item_t   res;
	out_item_t   hold_q;
	out_item_t   result_q;
	logic        result_valid_q;
	logic        do_write;
	logic        bump;
	wr_data_t    wr;
	logic [SLOTS-1:0] wr_en;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign last       = tok[SLOTS];
	// A result enters the output register when the scan ends or a waiting
	// result can move up.
	assign res_load   = out_free && ((state_q == S_SCAN && last.vld) || state_q == S_WAIT);

	// Head of the row: a fresh token per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q.vld   <= 1'b1;
			head_q.op    <= item.operation;
			head_q.frame <= item.frame_number;
			head_q.idx   <= item.slot_index;
			head_q.pos   <= '0;
			head_q.found <= 1'b0;
			head_q.best  <= '0;
			head_q.pick  <= '0;
		end else begin
			head_q.vld <= 1'b0;
		end
	end

	assign tok[0] = head_q;

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		assign wr_en[k] = do_write && (last.pick == SLOT_W'(k));

		flsc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (accept),
			.counter (counter_q),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.wr_en   (wr_en[k]),
			.wr      (wr)
		);
	end

	// Outcome of the scan once the token leaves the last cell.
	always_comb begin
		res      = '0;
		do_write = 1'b0;
		bump     = 1'b0;
		wr.tag   = last.frame;
		wr.stamp = counter_q;
		case (last.op)
			OP_LOOKUP: begin
				if (last.found) begin
					res.status = ST_DONE;
					res.slot   = 3'(last.pick);
					do_write   = last.vld;
					bump       = last.vld;
				end else begin
					res.status = ST_MISS;
				end
			end
			OP_ALLOCATE: begin
				res.status = ST_DONE;
				res.slot   = 3'(last.pick);
				wr.tag     = RESERVED_TAG;
				wr.stamp   = counter_q + RESERVE_AHEAD;
				do_write   = last.vld;
			end
			OP_FILL: begin
				res.slot = last.idx;
				if (last.found) begin
					res.status = ST_DONE;
					do_write   = last.vld;
					bump       = last.vld;
				end else begin
					res.status = ST_NOT_RESERVED;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (bump) begin
			counter_q <= counter_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last.vld) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && last.vld) begin
			if (out_free) begin
				result_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (state_q == S_WAIT && out_free) begin
			result_q <= hold_q;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN && head_q.vld))
		else $error("accepted item did not start a scan");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> state_q == S_SCAN)
		else $error("scan token finished outside of a scan");

	a_counter_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(counter_q != $past(counter_q)) |-> $past(state_q == S_SCAN && last.vld))
		else $error("use counter moved without a finished scan");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wr_en))
		else $error("more than one slot written at once");

endmodule

`default_nettype wire
